// ===== src/assert_macros.svh =====
// Shared assertion macros for the request stream parser.
// Each macro expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Condition at one edge implies a property at the next edge.
`define ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== src/rrsp_pkg.sv =====
`default_nettype none

package rrsp_pkg;

    // Protocol characters
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    // Header number accumulator saturates at its all-ones value
    localparam int ACC_W = 17;
    localparam logic [ACC_W-1:0] ACC_MAX = '1;

    // Fixed widths of the result fields and configuration registers
    localparam int IDX_W  = 6;
    localparam int LEN_W  = 16;
    localparam int SLOT_W = 4;
    localparam int MARGS_W = 7;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes
    localparam logic CFG_MAX_ARGS    = 1'b0;
    localparam logic CFG_MAX_ARG_LEN = 1'b1;

    typedef enum logic [3:0] {
        PH_HUNT,
        PH_CNT_FIRST,
        PH_CNT_MORE,
        PH_CNT_LF,
        PH_DOLLAR,
        PH_LEN_FIRST,
        PH_LEN_MORE,
        PH_LEN_LF,
        PH_DATA,
        PH_DATA_CR,
        PH_DATA_LF
    } phase_t;

    typedef enum logic [1:0] {
        KIND_DATA     = 2'd0,
        KIND_ARG_DONE = 2'd1,
        KIND_ERROR    = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_NO_DOLLAR = 2'd1,
        ERR_SYNTAX    = 2'd2,
        ERR_RANGE     = 2'd3
    } err_t;

    typedef struct packed {
        kind_t              kind;
        logic [7:0]         data_byte;
        logic [IDX_W-1:0]   arg_index;
        logic [LEN_W-1:0]   arg_length;
        logic               command_done;
        logic [SLOT_W-1:0]  command_slot;
        err_t               error_code;
    } result_t;

endpackage

`default_nettype wire

// ===== src/rrsp_in_stage.sv =====
`default_nettype none

module rrsp_in_stage
    import rrsp_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] rx_byte,
    input  wire logic       advance,
    output logic            byte_valid,
    output logic [7:0]      byte_value
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic       take;

    // Take a new item whenever the held one is empty or leaving
    assign in_ready   = !valid_reg || advance;
    assign take       = in_valid && in_ready;
    assign valid_next = take ? 1'b1 : (advance ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Hold the received byte
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            byte_reg <= rx_byte;
        end
    end

    assign byte_valid = valid_reg;
    assign byte_value = byte_reg;

endmodule

`default_nettype wire

// ===== src/rrsp_core.sv =====
`default_nettype none

module rrsp_core
    import rrsp_pkg::*;
#(
    parameter int MAX_ARGS    = 64,
    parameter int LEN_BITS    = 16,
    parameter int QUEUE_SLOTS = 16
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic                  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  fire,
    input  wire logic [7:0]            byte_value,
    output logic                       res_valid,
    output result_t                    res
);

    `include "assert_macros.svh"

    localparam int AC_W   = (MAX_ARGS > 1) ? $clog2(MAX_ARGS) : 1;
    localparam int AE_W   = $clog2(MAX_ARGS + 1);
    localparam int ALEN_W = (LEN_BITS < LEN_W) ? LEN_BITS : LEN_W;
    localparam int SP_W   = $clog2(QUEUE_SLOTS);
    localparam logic [SP_W-1:0] SLOT_LAST = SP_W'(QUEUE_SLOTS - 1);
    localparam int LEN_CAP_I = (LEN_BITS >= ACC_W) ? ((1 << ACC_W) - 1)
                                                   : ((1 << LEN_BITS) - 1);
    localparam logic [ACC_W-1:0] LEN_CAP   = ACC_W'(LEN_CAP_I);
    localparam logic [ACC_W-1:0] ARGS_CAP  = ACC_W'(MAX_ARGS);

    // Configuration registers
    logic [MARGS_W-1:0] max_args_reg;
    logic [LEN_W-1:0]   max_arg_len_reg;

    // Parser state
    phase_t             phase_reg,   phase_next;
    logic [ACC_W-1:0]   accum_reg,   accum_next;
    logic [AE_W-1:0]    args_exp_reg, args_exp_next;
    logic [AC_W-1:0]    arg_cnt_reg, arg_cnt_next;
    logic [ALEN_W-1:0]  left_reg,    left_next;
    logic [ALEN_W-1:0]  len_reg,     len_next;
    logic [SP_W-1:0]    slot_reg,    slot_next;

    logic               is_digit;
    logic [3:0]         digit_val;
    logic [ACC_W+3:0]   mul_sum;
    logic [ACC_W-1:0]   accum_sat;
    logic               fail_en;
    err_t               fail_code;
    logic [AE_W:0]      cnt_plus;
    logic               last_arg;
    logic               cnt_bad;
    logic               len_bad;
    logic [AC_W+IDX_W-1:0]    idx_ext;
    logic [ALEN_W+LEN_W-1:0]  len_ext;
    logic [SP_W+SLOT_W-1:0]   slot_ext;

    // Write configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_args_reg    <= MARGS_W'(64);
            max_arg_len_reg <= '1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MAX_ARGS:    max_args_reg    <= cfg_data[MARGS_W-1:0];
                CFG_MAX_ARG_LEN: max_arg_len_reg <= cfg_data[LEN_W-1:0];
                default:         max_args_reg    <= max_args_reg;
            endcase
        end
    end

    // Decode digit and advance the times-ten accumulator with saturation
    assign is_digit  = (byte_value >= CH_ZERO) && (byte_value <= CH_NINE);
    assign digit_val = 4'(byte_value - CH_ZERO);
    assign mul_sum   = {accum_reg, 3'b000} + {2'b00, accum_reg, 1'b0}
                     + (ACC_W+4)'(digit_val);
    assign accum_sat = (mul_sum > (ACC_W+4)'(ACC_MAX)) ? ACC_MAX : mul_sum[ACC_W-1:0];

    // Range checks on completed headers
    assign cnt_bad = (accum_reg == '0) || (accum_reg > ACC_W'(max_args_reg))
                   || (accum_reg > ARGS_CAP);
    assign len_bad = (accum_reg == '0) || (accum_reg > ACC_W'(max_arg_len_reg))
                   || (accum_reg > LEN_CAP);

    assign cnt_plus = (AE_W+1)'(arg_cnt_reg) + 1'b1;
    assign last_arg = cnt_plus >= (AE_W+1)'(args_exp_reg);

    // Fit internal widths to the result fields
    assign idx_ext  = (AC_W+IDX_W)'(arg_cnt_reg);
    assign len_ext  = (ALEN_W+LEN_W)'(len_reg);
    assign slot_ext = (SP_W+SLOT_W)'(slot_reg);

    // Next state and result for the held byte
    always_comb
    begin
        phase_next    = phase_reg;
        accum_next    = accum_reg;
        args_exp_next = args_exp_reg;
        arg_cnt_next  = arg_cnt_reg;
        left_next     = left_reg;
        len_next      = len_reg;
        slot_next     = slot_reg;
        fail_en       = 1'b0;
        fail_code     = ERR_NONE;
        res_valid     = 1'b0;
        res.kind         = KIND_DATA;
        res.data_byte    = byte_value;
        res.arg_index    = idx_ext[IDX_W-1:0];
        res.arg_length   = len_ext[LEN_W-1:0];
        res.command_done = 1'b0;
        res.command_slot = slot_ext[SLOT_W-1:0];
        res.error_code   = ERR_NONE;

        case (phase_reg)
            PH_HUNT:
            begin
                if (byte_value == CH_STAR)
                begin
                    accum_next = '0;
                    phase_next = PH_CNT_FIRST;
                end
            end
            PH_CNT_FIRST, PH_LEN_FIRST:
            begin
                if (is_digit)
                begin
                    accum_next = ACC_W'(digit_val);
                    phase_next = (phase_reg == PH_CNT_FIRST) ? PH_CNT_MORE : PH_LEN_MORE;
                end
                else
                begin
                    fail_en   = 1'b1;
                    fail_code = (byte_value == CH_MINUS) ? ERR_RANGE : ERR_SYNTAX;
                end
            end
            PH_CNT_MORE, PH_LEN_MORE:
            begin
                if (is_digit)
                begin
                    accum_next = accum_sat;
                end
                else if (byte_value == CH_CR)
                begin
                    phase_next = (phase_reg == PH_CNT_MORE) ? PH_CNT_LF : PH_LEN_LF;
                end
                else
                begin
                    fail_en   = 1'b1;
                    fail_code = ERR_SYNTAX;
                end
            end
            PH_CNT_LF:
            begin
                if (byte_value != CH_LF)
                begin
                    fail_en   = 1'b1;
                    fail_code = ERR_SYNTAX;
                end
                else if (cnt_bad)
                begin
                    fail_en   = 1'b1;
                    fail_code = ERR_RANGE;
                end
                else
                begin
                    args_exp_next = accum_reg[AE_W-1:0];
                    arg_cnt_next  = '0;
                    phase_next    = PH_DOLLAR;
                end
            end
            PH_DOLLAR:
            begin
                if (byte_value != CH_DOLLAR)
                begin
                    fail_en   = 1'b1;
                    fail_code = ERR_NO_DOLLAR;
                end
                else
                begin
                    accum_next = '0;
                    phase_next = PH_LEN_FIRST;
                end
            end
            PH_LEN_LF:
            begin
                if (byte_value != CH_LF)
                begin
                    fail_en   = 1'b1;
                    fail_code = ERR_SYNTAX;
                end
                else if (len_bad)
                begin
                    fail_en   = 1'b1;
                    fail_code = ERR_RANGE;
                end
                else
                begin
                    len_next   = accum_reg[ALEN_W-1:0];
                    left_next  = accum_reg[ALEN_W-1:0];
                    phase_next = PH_DATA;
                end
            end
            PH_DATA:
            begin
                // Forward the data byte and count down the argument
                res_valid = 1'b1;
                left_next = left_reg - 1'b1;
                if (left_reg == ALEN_W'(1))
                begin
                    phase_next = PH_DATA_CR;
                end
            end
            PH_DATA_CR:
            begin
                if (byte_value != CH_CR)
                begin
                    fail_en   = 1'b1;
                    fail_code = ERR_SYNTAX;
                end
                else
                begin
                    phase_next = PH_DATA_LF;
                end
            end
            PH_DATA_LF:
            begin
                if (byte_value != CH_LF)
                begin
                    fail_en   = 1'b1;
                    fail_code = ERR_SYNTAX;
                end
                else
                begin
                    // Report argument complete; close the command on the last one
                    res_valid        = 1'b1;
                    res.kind         = KIND_ARG_DONE;
                    res.data_byte    = '0;
                    res.command_done = last_arg;
                    if (last_arg)
                    begin
                        slot_next     = (slot_reg == SLOT_LAST) ? '0 : slot_reg + 1'b1;
                        arg_cnt_next  = '0;
                        args_exp_next = '0;
                        phase_next    = PH_HUNT;
                    end
                    else
                    begin
                        arg_cnt_next = arg_cnt_reg + 1'b1;
                        phase_next   = PH_DOLLAR;
                    end
                end
            end
            default:
            begin
                phase_next = PH_HUNT;
            end
        endcase

        // Flag framing error, drop the command and hunt again
        if (fail_en)
        begin
            res_valid      = 1'b1;
            res.kind       = KIND_ERROR;
            res.data_byte  = byte_value;
            res.arg_length = '0;
            res.error_code = fail_code;
            phase_next     = PH_HUNT;
            accum_next     = '0;
            args_exp_next  = '0;
            arg_cnt_next   = '0;
            left_next      = '0;
        end
    end

    // Advance parser state on each processed item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HUNT;
            accum_reg    <= '0;
            args_exp_reg <= '0;
            arg_cnt_reg  <= '0;
            left_reg     <= '0;
            len_reg      <= '0;
            slot_reg     <= '0;
        end
        else if (fire)
        begin
            phase_reg    <= phase_next;
            accum_reg    <= accum_next;
            args_exp_reg <= args_exp_next;
            arg_cnt_reg  <= arg_cnt_next;
            left_reg     <= left_next;
            len_reg      <= len_next;
            slot_reg     <= slot_next;
        end
    end

    `ASSERT_ALWAYS(a_data_left_nonzero, (phase_reg == PH_DATA) |-> (left_reg != '0), "data phase with no bytes left")
    `ASSERT_ALWAYS(a_counter_in_range, (phase_reg == PH_DOLLAR || phase_reg == PH_DATA || phase_reg == PH_DATA_LF) |-> (AE_W'(arg_cnt_reg) < args_exp_reg), "argument index beyond declared count")
    `ASSERT_NEXT(a_error_hunts, fire && res_valid && res.kind == KIND_ERROR, phase_reg == PH_HUNT, "parser did not resume hunting after error")

endmodule

`default_nettype wire

// ===== src/rrsp_out_stage.sv =====
`default_nettype none

module rrsp_out_stage
    import rrsp_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    load,
    input  wire result_t res_in,
    input  wire logic    out_ready,
    output logic         out_valid,
    output result_t      res_out,
    output logic         slot_free
);

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    // Slot is free when empty or being taken this cycle
    assign slot_free  = !valid_reg || out_ready;
    assign valid_next = load ? 1'b1 : (out_ready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Hold the result until the receiver takes it
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res_in;
        end
    end

    assign out_valid = valid_reg;
    assign res_out   = res_reg;

endmodule

`default_nettype wire

// ===== src/resp_request_stream_parser_unit.sv =====
// Request stream parser for arrays of bulk strings.
// Input channel: in_valid/in_ready with one received byte (rx_byte) per item.
// Output channel: out_valid/out_ready with zero or one result per input byte:
// a data byte tagged with its argument index and declared length, an
// argument-complete mark (command_done on the last argument, command_slot
// giving the wrapping slot of the command), or a framing error with its code.
// Bytes outside a request are dropped until '*' is seen.
// Configuration: cfg_we writes cfg_data to register cfg_index
// (0 max_args, 1 max_arg_len) in the same cycle; write only while idle.
// Path: an accepted byte is held in the input register, then parsed into the
// result register once that is free; its result is offered from there.
// Throughput: one byte per cycle while the receiver keeps out_ready high.
// Reset: parser hunts for '*', slot counter is zero, max_args is 64 and
// max_arg_len is 65535; no results are pending.
// Stall: while out_ready is low a pending result holds; an empty input
// register takes one more byte, then in_ready drops until the result is taken.
`default_nettype none

module resp_request_stream_parser_unit
    import rrsp_pkg::*;
#(
    parameter int MAX_ARGS    = 64,
    parameter int LEN_BITS    = 16,
    parameter int QUEUE_SLOTS = 16
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic                  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [7:0]            rx_byte,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [1:0]                 kind,
    output logic [7:0]                 data_byte,
    output logic [IDX_W-1:0]           arg_index,
    output logic [LEN_W-1:0]           arg_length,
    output logic                       command_done,
    output logic [SLOT_W-1:0]          command_slot,
    output logic [1:0]                 error_code
);

    `include "assert_macros.svh"

    logic       byte_valid;
    logic [7:0] byte_value;
    logic       slot_free;
    logic       fire;
    logic       res_valid;
    result_t    res;
    result_t    res_out;

    // Process the held byte when the result register can take its result
    assign fire = byte_valid && slot_free;

    rrsp_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .rx_byte    (rx_byte),
        .advance    (fire),
        .byte_valid (byte_valid),
        .byte_value (byte_value)
    );

    rrsp_core #(
        .MAX_ARGS    (MAX_ARGS),
        .LEN_BITS    (LEN_BITS),
        .QUEUE_SLOTS (QUEUE_SLOTS)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fire       (fire),
        .byte_value (byte_value),
        .res_valid  (res_valid),
        .res        (res)
    );

    rrsp_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (fire && res_valid),
        .res_in    (res),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .res_out   (res_out),
        .slot_free (slot_free)
    );

    // Unpack the result onto the output ports
    assign kind         = res_out.kind;
    assign data_byte    = res_out.data_byte;
    assign arg_index    = res_out.arg_index;
    assign arg_length   = res_out.arg_length;
    assign command_done = res_out.command_done;
    assign command_slot = res_out.command_slot;
    assign error_code   = res_out.error_code;

    `ASSERT_ALWAYS(a_done_kind, out_valid && command_done |-> kind == KIND_ARG_DONE, "stray done")

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
module tb;
    import rrsp_pkg::*;

    // Parameter values the block is built with
    localparam int DUT_MAX_ARGS = 64;
    localparam int DUT_LEN_BITS = 16;
    localparam int N_SETTINGS   = 7;
    localparam int DIR_ROWS     = 28;

    typedef struct packed {
        logic [7:0] rx;
        err_t       code;
    } dir_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic                  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    logic [7:0]            rx_byte;
    logic                  out_valid;
    logic                  out_ready;
    logic [1:0]            kind;
    logic [7:0]            data_byte;
    logic [IDX_W-1:0]      arg_index;
    logic [LEN_W-1:0]      arg_length;
    logic                  command_done;
    logic [SLOT_W-1:0]     command_slot;
    logic [1:0]            error_code;

    // Error code typed in for a directed row, ERR_NONE when the predictor decides
    err_t                  dir_code;

    // Parser state mirrored by the predictor
    phase_t                st_phase     = PH_HUNT;
    int unsigned           num_acc      = 0;
    int unsigned           cnt_declared = 0;
    int unsigned           cur_arg      = 0;
    int unsigned           remaining    = 0;
    logic [LEN_W-1:0]      cur_len      = '0;
    logic [SLOT_W-1:0]     slot_q       = '0;
    int unsigned           lim_args     = 64;
    int unsigned           lim_len      = 65535;

    result_t               pending_tokens[$];
    logic [7:0]            frame_bytes[$];
    int                    mismatch_count = 0;
    int                    results_seen   = 0;
    int                    burst_left     = 0;

    // Register settings walked by the random part
    int set_args  [N_SETTINGS] = '{1, 64, 3, 127, 64, 2, 10};
    int set_lens  [N_SETTINGS] = '{65535, 0, 5, 16, 65535, 1, 300};
    int set_quota [N_SETTINGS] = '{260, 80, 260, 260, 260, 220, 260};

    // Directed stimulus: framing errors first, while the slot is still zero
    dir_row_t dir_rows [DIR_ROWS] = '{
        '{CH_STAR, ERR_NONE}, '{CH_CR, ERR_SYNTAX},
        '{CH_STAR, ERR_NONE}, '{CH_MINUS, ERR_RANGE},
        '{CH_STAR, ERR_NONE}, '{CH_ZERO, ERR_NONE}, '{CH_CR, ERR_NONE},
        '{CH_LF, ERR_RANGE},
        '{CH_STAR, ERR_NONE}, '{CH_STAR, ERR_SYNTAX}, '{CH_ZERO + 8'd1, ERR_NONE},
        '{CH_STAR, ERR_NONE}, '{CH_ZERO + 8'd1, ERR_NONE}, '{CH_CR, ERR_NONE},
        '{CH_LF, ERR_NONE}, '{8'h78, ERR_NO_DOLLAR},
        '{CH_STAR, ERR_NONE}, '{CH_ZERO + 8'd1, ERR_NONE}, '{CH_CR, ERR_NONE},
        '{CH_LF, ERR_NONE}, '{CH_DOLLAR, ERR_NONE}, '{CH_ZERO + 8'd2, ERR_NONE},
        '{CH_CR, ERR_NONE}, '{CH_LF, ERR_NONE}, '{8'h00, ERR_NONE},
        '{8'hFF, ERR_NONE}, '{CH_CR, ERR_NONE}, '{CH_LF, ERR_NONE}
    };

    resp_request_stream_parser_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .data_byte    (data_byte),
        .arg_index    (arg_index),
        .arg_length   (arg_length),
        .command_done (command_done),
        .command_slot (command_slot),
        .error_code   (error_code)
    );

    always #5 clk = ~clk;

    // Report one mismatch and count it; keep the log short on a broken build
    task automatic flag_mismatch(input string what, input logic [31:0] got_v,
                                 input logic [31:0] want_v);
        mismatch_count++;
        if (mismatch_count <= 50)
            $display("ERROR: result %0d %s: got 0x%0h expected 0x%0h",
                     results_seen, what, got_v, want_v);
    endtask

    // Emit a framing error and go back to hunting for the array marker
    function automatic bit framing_error(input logic [7:0] b, input err_t code,
                                         output result_t r);
        r              = '0;
        r.kind         = KIND_ERROR;
        r.data_byte    = b;
        r.arg_index    = IDX_W'(cur_arg);
        r.command_slot = slot_q;
        r.error_code   = code;
        st_phase       = PH_HUNT;
        num_acc        = 0;
        cnt_declared   = 0;
        cur_arg        = 0;
        remaining      = 0;
        return 1'b1;
    endfunction

    // Advance the parser by one byte; return 1 when the byte yields a result
    function automatic bit parse_rx_byte(input logic [7:0] b, output result_t r);
        bit          is_digit;
        bit          last;
        int unsigned v;
        is_digit      = (b >= CH_ZERO) && (b <= CH_NINE);
        r             = '0;
        parse_rx_byte = 1'b0;
        case (st_phase)
            PH_HUNT:
                if (b == CH_STAR)
                begin
                    num_acc  = 0;
                    st_phase = PH_CNT_FIRST;
                end
            PH_CNT_FIRST, PH_LEN_FIRST:
                if (is_digit)
                begin
                    num_acc = b - CH_ZERO;
                    if (st_phase == PH_CNT_FIRST)
                        st_phase = PH_CNT_MORE;
                    else
                        st_phase = PH_LEN_MORE;
                end
                else if (b == CH_MINUS)
                    parse_rx_byte = framing_error(b, ERR_RANGE, r);
                else
                    parse_rx_byte = framing_error(b, ERR_SYNTAX, r);
            PH_CNT_MORE, PH_LEN_MORE:
                if (is_digit)
                begin
                    // Saturate the accumulator at its all-ones value
                    v       = num_acc * 10 + (b - CH_ZERO);
                    num_acc = (v > ACC_MAX) ? ACC_MAX : v;
                end
                else if (b == CH_CR)
                begin
                    if (st_phase == PH_CNT_MORE)
                        st_phase = PH_CNT_LF;
                    else
                        st_phase = PH_LEN_LF;
                end
                else
                    parse_rx_byte = framing_error(b, ERR_SYNTAX, r);
            PH_CNT_LF:
                if (b != CH_LF)
                    parse_rx_byte = framing_error(b, ERR_SYNTAX, r);
                else if (num_acc == 0 || num_acc > lim_args || num_acc > DUT_MAX_ARGS)
                    parse_rx_byte = framing_error(b, ERR_RANGE, r);
                else
                begin
                    cnt_declared = num_acc;
                    cur_arg      = 0;
                    st_phase     = PH_DOLLAR;
                end
            PH_DOLLAR:
                if (b != CH_DOLLAR)
                    parse_rx_byte = framing_error(b, ERR_NO_DOLLAR, r);
                else
                begin
                    num_acc  = 0;
                    st_phase = PH_LEN_FIRST;
                end
            PH_LEN_LF:
                if (b != CH_LF)
                    parse_rx_byte = framing_error(b, ERR_SYNTAX, r);
                else if (num_acc == 0 || num_acc > lim_len
                         || (num_acc >> DUT_LEN_BITS) != 0)
                    parse_rx_byte = framing_error(b, ERR_RANGE, r);
                else
                begin
                    cur_len   = LEN_W'(num_acc);
                    remaining = num_acc;
                    st_phase  = PH_DATA;
                end
            PH_DATA:
            begin
                r.kind         = KIND_DATA;
                r.data_byte    = b;
                r.arg_index    = IDX_W'(cur_arg);
                r.arg_length   = cur_len;
                r.command_slot = slot_q;
                parse_rx_byte  = 1'b1;
                remaining      = remaining - 1;
                if (remaining == 0)
                    st_phase = PH_DATA_CR;
            end
            PH_DATA_CR:
                if (b != CH_CR)
                    parse_rx_byte = framing_error(b, ERR_SYNTAX, r);
                else
                    st_phase = PH_DATA_LF;
            PH_DATA_LF:
                if (b != CH_LF)
                    parse_rx_byte = framing_error(b, ERR_SYNTAX, r);
                else
                begin
                    last           = (cur_arg + 1 >= cnt_declared);
                    r.kind         = KIND_ARG_DONE;
                    r.arg_index    = IDX_W'(cur_arg);
                    r.arg_length   = cur_len;
                    r.command_done = last;
                    r.command_slot = slot_q;
                    parse_rx_byte  = 1'b1;
                    if (last)
                    begin
                        // Slot counter wraps over its sixteen values
                        slot_q       = slot_q + 1'b1;
                        cur_arg      = 0;
                        cnt_declared = 0;
                        st_phase     = PH_HUNT;
                    end
                    else
                    begin
                        cur_arg  = cur_arg + 1;
                        st_phase = PH_DOLLAR;
                    end
                end
            default:
                st_phase = PH_HUNT;
        endcase
    endfunction

    // Track register writes, check results, predict accepted items
    always @(posedge clk)
    begin : monitor
        result_t got;
        result_t want;
        result_t res;
        bit      has_res;
        if (rst_n)
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_MAX_ARGS)
                    lim_args = cfg_data[MARGS_W-1:0];
                else
                    lim_len = cfg_data;
            end
            if (out_valid && out_ready)
            begin
                results_seen++;
                got.kind         = kind_t'(kind);
                got.data_byte    = data_byte;
                got.arg_index    = arg_index;
                got.arg_length   = arg_length;
                got.command_done = command_done;
                got.command_slot = command_slot;
                got.error_code   = err_t'(error_code);
                if (pending_tokens.size() == 0)
                    flag_mismatch("with nothing pending, kind", kind, 0);
                else
                begin
                    want = pending_tokens.pop_front();
                    if (got.kind !== want.kind)
                        flag_mismatch("kind", got.kind, want.kind);
                    if (got.data_byte !== want.data_byte)
                        flag_mismatch("data_byte", got.data_byte, want.data_byte);
                    if (got.arg_index !== want.arg_index)
                        flag_mismatch("arg_index", got.arg_index, want.arg_index);
                    if (got.arg_length !== want.arg_length)
                        flag_mismatch("arg_length", got.arg_length, want.arg_length);
                    if (got.command_done !== want.command_done)
                        flag_mismatch("command_done", got.command_done, want.command_done);
                    if (got.command_slot !== want.command_slot)
                        flag_mismatch("command_slot", got.command_slot, want.command_slot);
                    if (got.error_code !== want.error_code)
                        flag_mismatch("error_code", got.error_code, want.error_code);
                end
            end
            if (in_valid && in_ready)
            begin
                has_res = parse_rx_byte(rx_byte, res);
                if (dir_code != ERR_NONE)
                begin
                    // Directed error row: error on this byte, first argument, slot 0
                    want            = '0;
                    want.kind       = KIND_ERROR;
                    want.data_byte  = rx_byte;
                    want.error_code = dir_code;
                    pending_tokens.push_back(want);
                end
                else if (has_res)
                    pending_tokens.push_back(res);
            end
        end
    end

    // Offer one item and hold it until accepted; pause between bursts
    task automatic send_byte(input logic [7:0] b, input err_t code);
        int gap;
        in_valid <= 1'b1;
        rx_byte  <= b;
        dir_code <= code;
        do
            @(posedge clk);
        while (!in_ready);
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Stop offering, drain every pending result, let the pipeline empty
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_tokens.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Raise the write strobe; the caller lowers it after the last write
    task automatic write_reg(input logic idx, input int value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(value);
        @(posedge clk);
    endtask

    task automatic push_number(input int unsigned n);
        string digits;
        digits = $sformatf("%0d", n);
        for (int i = 0; i < digits.len(); i++)
            frame_bytes.push_back(digits[i]);
    endtask

    task automatic push_crlf();
        frame_bytes.push_back(CH_CR);
        frame_bytes.push_back(CH_LF);
    endtask

    // Build one request, mostly well formed, sometimes broken on purpose
    task automatic build_command();
        int unsigned arg_cap;
        int unsigned n_args;
        int unsigned len;
        int unsigned len_cap;
        int unsigned fault;
        int unsigned bad_arg;
        int unsigned pos;
        logic [7:0]  specials [4];
        specials = '{CH_STAR, CH_DOLLAR, CH_CR, CH_LF};
        arg_cap  = (lim_args > DUT_MAX_ARGS) ? DUT_MAX_ARGS : lim_args;
        fault    = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 7) : 0;
        n_args   = $urandom_range(1, (arg_cap < 4) ? arg_cap : 4);
        if ($urandom_range(0, 9) == 0)
            n_args = $urandom_range(1, arg_cap);
        if ($urandom_range(0, 39) == 0)
            n_args = arg_cap;
        bad_arg = $urandom_range(0, n_args - 1);
        frame_bytes.delete();

        // Line noise ahead of the array marker
        if ($urandom_range(0, 5) == 0)
            repeat ($urandom_range(1, 4)) frame_bytes.push_back(8'($urandom));

        // Array header
        frame_bytes.push_back(CH_STAR);
        if (fault == 2)
            frame_bytes.push_back(CH_MINUS);
        if ($urandom_range(0, 7) == 0)
            frame_bytes.push_back(CH_ZERO);
        if (fault == 1)
            case ($urandom_range(0, 2))
                0: push_number(0);
                1: push_number(arg_cap + 1);
                default: push_number(9999999);
            endcase
        else
            push_number(n_args);
        push_crlf();

        // Bulk strings
        for (int a = 0; a < n_args; a++)
        begin
            if (lim_len == 0)
                len = $urandom_range(1, 3);
            else
            begin
                len_cap = (lim_len < 8) ? lim_len : 8;
                if ($urandom_range(0, 15) == 0)
                    len_cap = (lim_len < 64) ? lim_len : 64;
                if ($urandom_range(0, 149) == 0)
                    len_cap = (lim_len < 300) ? lim_len : 300;
                len = $urandom_range(1, len_cap);
            end
            frame_bytes.push_back(CH_DOLLAR);
            if (fault == 3 && a == bad_arg)
                case ($urandom_range(0, 2))
                    0: push_number(0);
                    1: push_number(lim_len + 1);
                    default: push_number(999999);
                endcase
            else if (!(fault == 7 && a == bad_arg))
                push_number(len);
            push_crlf();
            if (fault == 6 && a == bad_arg)
                len = len + 1;
            repeat (len)
            begin
                if ($urandom_range(0, 7) == 0)
                    frame_bytes.push_back(specials[$urandom_range(0, 3)]);
                else
                    frame_bytes.push_back(8'($urandom_range(0, 255)));
            end
            push_crlf();
        end

        // Corrupt or drop one byte anywhere in the request
        pos = $urandom_range(0, frame_bytes.size() - 1);
        if (fault == 4)
            frame_bytes[pos] = 8'($urandom_range(0, 255));
        if (fault == 5)
            frame_bytes.delete(pos);
    endtask

    // Receiver: segments of varying stall patterns plus two long hold-offs
    initial
    begin : receiver
        int hold_step;
        int seg_left;
        int mode;
        int cyc;
        int hold_marks [2];
        hold_marks = '{300, 1200};
        hold_step  = 0;
        seg_left   = 0;
        mode       = 0;
        cyc        = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            cyc++;
            if (hold_step < 2 && results_seen >= hold_marks[hold_step])
            begin
                // Hold off long enough for the block to fill and stall its input
                out_ready <= 1'b0;
                repeat (400) @(posedge clk);
                hold_step++;
            end
            else
            begin
                if (seg_left == 0)
                begin
                    mode     = $urandom_range(0, 3);
                    seg_left = $urandom_range(10, 150);
                end
                seg_left--;
                case (mode)
                    0: out_ready <= 1'b1;
                    1: out_ready <= 1'($urandom_range(0, 1));
                    2: out_ready <= ($urandom_range(0, 7) != 0);
                    default: out_ready <= (cyc % 3 == 0);
                endcase
            end
        end
    end

    // Run limit
    initial
    begin
        #3000000;
        $display("Regression FAIL");
        $finish;
    end

    // Stimulus: reset, directed table, then random requests per setting
    initial
    begin : driver
        int sent;
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= CFG_MAX_ARGS;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        rx_byte   <= '0;
        dir_code  <= ERR_NONE;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_byte(dir_rows[i].rx, dir_rows[i].code);

        for (int p = 0; p < N_SETTINGS; p++)
        begin
            wait_idle();
            write_reg(CFG_MAX_ARGS, set_args[p]);
            write_reg(CFG_MAX_ARG_LEN, set_lens[p]);
            cfg_we <= 1'b0;
            sent = 0;
            while (sent < set_quota[p])
            begin
                build_command();
                foreach (frame_bytes[i])
                    send_byte(frame_bytes[i], ERR_NONE);
                sent += frame_bytes.size();
            end
        end

        wait_idle();
        if (mismatch_count == 0 && pending_tokens.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+src
src/rrsp_pkg.sv
src/rrsp_in_stage.sv
src/rrsp_core.sv
src/rrsp_out_stage.sv
src/resp_request_stream_parser_unit.sv
tb/sv/tb.sv
